[hdl/ccv_pkg.sv]
// Shared types and constants for the valid-region 2D cross-correlation core.
package ccv_pkg;

   localparam int CORR_BITS = 38;
   localparam int POS_BITS = 10;
   localparam int CFG_BITS = 11;
   localparam int CFG_IDX_BITS = 2;
   localparam int COEF_IDX_BITS = 3;

   typedef enum logic [CFG_IDX_BITS-1:0] {
      REG_IMAGE_ROWS = 2'd0,
      REG_IMAGE_COLS = 2'd1,
      REG_TMPL_ROWS  = 2'd2,
      REG_TMPL_COLS  = 2'd3
   } reg_idx_type;

   typedef enum logic {
      ACT_COEF  = 1'b0,
      ACT_PIXEL = 1'b1
   } action_type;

   localparam logic [CFG_BITS-1:0] RST_IMAGE_ROWS = 11'd1024;
   localparam logic [CFG_BITS-1:0] RST_IMAGE_COLS = 11'd1024;
   localparam logic [CFG_BITS-1:0] RST_TMPL_ROWS = 11'd3;
   localparam logic [CFG_BITS-1:0] RST_TMPL_COLS = 11'd3;

   typedef struct packed {
      logic                     is_pixel;
      logic                     emit;
      logic                     last;
      logic [COEF_IDX_BITS-1:0] coef_row;
      logic [COEF_IDX_BITS-1:0] coef_col;
      logic [POS_BITS-1:0]      out_row;
      logic [POS_BITS-1:0]      out_col;
   } ctrl_type;

endpackage

[hdl/ccv_req_if.sv]
// Request channel: template coefficient writes and image pixels.
interface ccv_req_if #(parameter int SAMPLE_BITS = 16);
   import ccv_pkg::*;
   logic                          valid;
   logic                          ready;
   logic                          action;
   logic [COEF_IDX_BITS-1:0]      coef_row;
   logic [COEF_IDX_BITS-1:0]      coef_col;
   logic signed [SAMPLE_BITS-1:0] sample;
   modport source(output valid, action, coef_row, coef_col, sample, input ready);
   modport sink(input valid, action, coef_row, coef_col, sample, output ready);
endinterface

[hdl/ccv_rsp_if.sv]
// Response channel: correlation sums with their map position.
interface ccv_rsp_if;
   import ccv_pkg::*;
   logic                        valid;
   logic                        ready;
   logic signed [CORR_BITS-1:0] corr_value;
   logic [POS_BITS-1:0]         out_row;
   logic [POS_BITS-1:0]         out_col;
   logic                        last;
   modport source(output valid, corr_value, out_row, out_col, last, input ready);
   modport sink(input valid, corr_value, out_row, out_col, last, output ready);
endinterface

[hdl/ccv_front.sv]
// Front end: accepts beats, tracks raster position and tags each beat.
module ccv_front #(
   parameter int MAX_ROWS = 1024,
   parameter int MAX_COLS = 1024,
   parameter int TMPL_MAX = 8,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   ccv_req_if.sink                              req_chan,
   input  logic                                 enable,
   input  logic [$clog2(MAX_ROWS+1)-1:0]        rows,
   input  logic [$clog2(MAX_COLS+1)-1:0]        cols,
   input  logic [$clog2(TMPL_MAX+1)-1:0]        tr,
   input  logic [$clog2(TMPL_MAX+1)-1:0]        tc,
   output logic                                 push_valid,
   input  logic                                 push_ready,
   output ccv_pkg::ctrl_type                    push_ctrl,
   output logic signed [SAMPLE_BITS-1:0]        push_sample,
   output logic [$clog2(MAX_COLS)-1:0]          push_addr
);
   import ccv_pkg::*;

   localparam int RW = $clog2(MAX_ROWS);
   localparam int CW = $clog2(MAX_COLS);
   localparam int RRW = $clog2(MAX_ROWS+1);
   localparam int CCW = $clog2(MAX_COLS+1);

   logic [RW-1:0]  row_ff, row_in;
   logic [CW-1:0]  col_ff, col_in;
   logic [RRW-1:0] row_p1;
   logic [CCW-1:0] col_p1;
   logic [15:0]    row_off, col_off;
   logic           end_line, end_image, emit, accept, is_pixel;

   assign req_chan.ready = enable && push_ready;
   assign accept = req_chan.valid && req_chan.ready;
   assign is_pixel = (req_chan.action == ACT_PIXEL);

   assign row_p1 = RRW'(row_ff) + RRW'(1);
   assign col_p1 = CCW'(col_ff) + CCW'(1);
   assign end_line = col_p1 >= cols;
   assign end_image = end_line && (row_p1 >= rows);
   assign emit = (16'(tr) <= 16'(rows)) && (16'(tc) <= 16'(cols))
      && (16'(row_p1) >= 16'(tr)) && (16'(col_p1) >= 16'(tc));
   assign row_off = 16'(row_p1) - 16'(tr);
   assign col_off = 16'(col_p1) - 16'(tc);

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (accept && is_pixel) begin
         priority if (end_image) begin
            row_in = '0;
            col_in = '0;
         end else if (end_line) begin
            row_in = row_ff + RW'(1);
            col_in = '0;
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   assign push_valid = req_chan.valid && enable;
   assign push_sample = req_chan.sample;
   assign push_addr = col_ff;

   always_comb begin
      push_ctrl.is_pixel = is_pixel;
      push_ctrl.emit = emit;
      push_ctrl.last = end_image;
      push_ctrl.coef_row = req_chan.coef_row;
      push_ctrl.coef_col = req_chan.coef_col;
      push_ctrl.out_row = row_off[POS_BITS-1:0];
      push_ctrl.out_col = col_off[POS_BITS-1:0];
   end

endmodule

[hdl/ccv_queue.sv]
// Two-entry queue between the front and back ends.
module ccv_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);
   logic [WIDTH-1:0] mem_ff [2];
   logic             wptr_ff, rptr_ff;
   logic [1:0]       count_ff;
   logic             push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_data = mem_ff[rptr_ff];
   assign push = push_valid && push_ready;
   assign pop = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (push) mem_ff[wptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) wptr_ff <= ~wptr_ff;
         if (pop) rptr_ff <= ~rptr_ff;
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end

endmodule

[hdl/ccv_back.sv]
// Back end: line buffer, window, template and the multiply-add pipeline.
module ccv_back #(
   parameter int MAX_COLS = 1024,
   parameter int TMPL_MAX = 8,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          pop_valid,
   output logic                          pop_ready,
   input  ccv_pkg::ctrl_type             pop_ctrl,
   input  logic signed [SAMPLE_BITS-1:0] pop_sample,
   input  logic [$clog2(MAX_COLS)-1:0]   pop_addr,
   input  logic [$clog2(TMPL_MAX+1)-1:0] tr,
   input  logic [$clog2(TMPL_MAX+1)-1:0] tc,
   output logic                          clear_busy,
   ccv_rsp_if.source                     rsp_chan
);
   import ccv_pkg::*;

   localparam int SB = SAMPLE_BITS;
   localparam int CW = $clog2(MAX_COLS);
   localparam int LW = (TMPL_MAX-1)*SB;
   localparam int TI = $clog2(TMPL_MAX);
   localparam int TW = $clog2(TMPL_MAX+1);
   localparam int PW = 2*SB;
   localparam int RSW = PW + TI;
   localparam int SUMW = PW + 2*TI;
   localparam int WIDE = (SUMW > CORR_BITS) ? SUMW : CORR_BITS;

   logic en;
   logic clr_busy_ff;
   logic [CW-1:0] clr_addr_ff;

   logic [LW-1:0] lbuf [MAX_COLS];
   logic [LW-1:0] rd_data_ff, byp_data_ff, line_rd, wr_data;
   logic byp_hit_ff;

   logic a_valid_ff;
   ctrl_type a_ctrl_ff;
   logic signed [SB-1:0] a_sample_ff;
   logic [CW-1:0] a_addr_ff;
   logic a_pix, a_coef_ok;
   logic [TI-1:0] cr, cc;

   logic signed [SB-1:0] colvec [TMPL_MAX];
   logic signed [SB-1:0] win_ff [TMPL_MAX][TMPL_MAX];
   logic signed [SB-1:0] tmpl_ff [TMPL_MAX][TMPL_MAX];
   logic signed [SB-1:0] tsel [TMPL_MAX][TMPL_MAX];

   logic b_valid_ff, c_valid_ff, d_valid_ff;
   ctrl_type b_ctrl_ff, c_ctrl_ff, d_ctrl_ff, o_ctrl_ff;
   logic signed [PW-1:0] prod_ff [TMPL_MAX][TMPL_MAX];
   logic signed [RSW-1:0] rsum_ff [TMPL_MAX];
   logic signed [RSW-1:0] rsum [TMPL_MAX];
   logic signed [SUMW-1:0] total;
   logic signed [WIDE-1:0] total_w;
   logic out_valid_ff;
   logic signed [CORR_BITS-1:0] corr_ff;

   assign en = !out_valid_ff || rsp_chan.ready;
   assign pop_ready = en && !clr_busy_ff;
   assign clear_busy = clr_busy_ff;

   // line buffer clear after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + CW'(1);
         if (clr_addr_ff == CW'(MAX_COLS-1)) clr_busy_ff <= 1'b0;
      end
   end

   assign a_pix = a_valid_ff && a_ctrl_ff.is_pixel;
   assign cr = TI'(a_ctrl_ff.coef_row);
   assign cc = TI'(a_ctrl_ff.coef_col);
   assign a_coef_ok = (32'(a_ctrl_ff.coef_row) < 32'(TMPL_MAX))
      && (32'(a_ctrl_ff.coef_col) < 32'(TMPL_MAX));

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         lbuf[clr_addr_ff] <= '0;
      end else if (en && a_pix) begin
         lbuf[a_addr_ff] <= wr_data;
      end
      if (en) rd_data_ff <= lbuf[pop_addr];
   end

   assign line_rd = byp_hit_ff ? byp_data_ff : rd_data_ff;

   always_comb begin
      colvec[0] = a_sample_ff;
      for (int i = 1; i < TMPL_MAX; i++) colvec[i] = line_rd[(i-1)*SB +: SB];
      for (int i = 1; i < TMPL_MAX; i++) wr_data[(i-1)*SB +: SB] = colvec[i-1];
   end

   always_comb begin
      for (int i = 0; i < TMPL_MAX; i++) begin
         for (int j = 0; j < TMPL_MAX; j++) begin
            tsel[i][j] = tmpl_ff[TI'(tr - TW'(1) - TW'(i))][TI'(tc - TW'(1) - TW'(j))];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ctrl_ff <= pop_ctrl;
         a_sample_ff <= pop_sample;
         a_addr_ff <= pop_addr;
         byp_hit_ff <= a_pix && (a_addr_ff == pop_addr);
         byp_data_ff <= wr_data;
         b_ctrl_ff <= a_ctrl_ff;
         c_ctrl_ff <= b_ctrl_ff;
         d_ctrl_ff <= c_ctrl_ff;
         o_ctrl_ff <= d_ctrl_ff;
         for (int i = 0; i < TMPL_MAX; i++) begin
            for (int j = 0; j < TMPL_MAX; j++) begin
               if ((TW'(i) < tr) && (TW'(j) < tc)) prod_ff[i][j] <= win_ff[i][j] * tsel[i][j];
               else prod_ff[i][j] <= '0;
            end
            rsum_ff[i] <= rsum[i];
         end
         corr_ff <= total_w[CORR_BITS-1:0];
      end
   end

   always_comb begin
      total = '0;
      for (int i = 0; i < TMPL_MAX; i++) begin
         rsum[i] = '0;
         for (int j = 0; j < TMPL_MAX; j++) rsum[i] = rsum[i] + RSW'(prod_ff[i][j]);
         total = total + SUMW'(rsum_ff[i]);
      end
      total_w = WIDE'(total);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < TMPL_MAX; i++) begin
            for (int j = 0; j < TMPL_MAX; j++) begin
               win_ff[i][j] <= '0;
               tmpl_ff[i][j] <= '0;
            end
         end
      end else if (en) begin
         a_valid_ff <= pop_valid && !clr_busy_ff;
         b_valid_ff <= a_pix && a_ctrl_ff.emit;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
         out_valid_ff <= d_valid_ff;
         if (a_pix) begin
            for (int i = 0; i < TMPL_MAX; i++) begin
               for (int j = TMPL_MAX-1; j >= 1; j--) win_ff[i][j] <= win_ff[i][j-1];
               win_ff[i][0] <= colvec[i];
            end
         end
         if (a_valid_ff && !a_ctrl_ff.is_pixel && a_coef_ok) tmpl_ff[cr][cc] <= a_sample_ff;
      end
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.corr_value = corr_ff;
   assign rsp_chan.out_row = o_ctrl_ff.out_row;
   assign rsp_chan.out_col = o_ctrl_ff.out_col;
   assign rsp_chan.last = o_ctrl_ff.last;

endmodule

[hdl/cross_correlation_2d_valid_core.sv]
// Valid-region 2D cross-correlation core, top level.
// Usage:
//  csr_we/csr_index/csr_data set image rows, image cols, template rows and
//  template cols (indexes 0..3); write only while the core is idle.
//  req_chan carries coefficient writes (action 0, by coef_row/coef_col) and
//  raster-order pixels (action 1). The core tracks pixel position itself.
//  rsp_chan gives one correlation sum per pixel whose template window lies
//  inside the image, with its map row/column; last marks the image's end.
// Throughput: one beat per cycle while no rsp is held and no clear runs; a pixel
//  leaves the line buffer read, window shift, multiply, row-sum and total-sum stages in order.
// Path: a beat goes from req accept through the queue, then queue pop with line
//  buffer read, window, products, row sums, total, to rsp valid.
// Reset: config returns to 1024 x 1024 image, 3 x 3 template; template,
//  window and position clear. The line buffer is then swept to zero across all
//  MAX_COLS addresses, during which req_chan.ready stays low.
// Stall: a held rsp freezes the back pipeline; the two-entry queue then
//  fills and req_chan.ready drops until the response is taken.
module cross_correlation_2d_valid_core #(
   parameter int MAX_COLS = 1024,
   parameter int MAX_ROWS = 1024,
   parameter int TMPL_MAX = 8,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   ccv_req_if.sink                               req_chan,
   ccv_rsp_if.source                             rsp_chan,
   input  logic                                  csr_we,
   input  logic [ccv_pkg::CFG_IDX_BITS-1:0]      csr_index,
   input  logic [ccv_pkg::CFG_BITS-1:0]          csr_data
);
   import ccv_pkg::*;

   localparam int CW = $clog2(MAX_COLS);
   localparam int RRW = $clog2(MAX_ROWS+1);
   localparam int CCW = $clog2(MAX_COLS+1);
   localparam int TW = $clog2(TMPL_MAX+1);
   localparam int QW = $bits(ctrl_type) + SAMPLE_BITS + CW;

   logic [CFG_BITS-1:0] rows_ff, cols_ff, trows_ff, tcols_ff;
   logic [RRW-1:0] rows;
   logic [CCW-1:0] cols;
   logic [TW-1:0]  tr, tc;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= RST_IMAGE_ROWS;
         cols_ff <= RST_IMAGE_COLS;
         trows_ff <= RST_TMPL_ROWS;
         tcols_ff <= RST_TMPL_COLS;
      end else if (csr_we) begin
         unique case (reg_idx_type'(csr_index))
            REG_IMAGE_ROWS: rows_ff <= csr_data;
            REG_IMAGE_COLS: cols_ff <= csr_data;
            REG_TMPL_ROWS:  trows_ff <= {7'd0, csr_data[3:0]};
            REG_TMPL_COLS:  tcols_ff <= {7'd0, csr_data[3:0]};
            default: ;
         endcase
      end
   end

   always_comb begin
      if (rows_ff == '0) rows = RRW'(1);
      else if (32'(rows_ff) > 32'(MAX_ROWS)) rows = RRW'(MAX_ROWS);
      else rows = RRW'(rows_ff);
      if (cols_ff == '0) cols = CCW'(1);
      else if (32'(cols_ff) > 32'(MAX_COLS)) cols = CCW'(MAX_COLS);
      else cols = CCW'(cols_ff);
      if (trows_ff == '0) tr = TW'(1);
      else if (32'(trows_ff) > 32'(TMPL_MAX)) tr = TW'(TMPL_MAX);
      else tr = TW'(trows_ff);
      if (tcols_ff == '0) tc = TW'(1);
      else if (32'(tcols_ff) > 32'(TMPL_MAX)) tc = TW'(TMPL_MAX);
      else tc = TW'(tcols_ff);
   end

   logic                          clear_busy;
   logic                          push_valid, push_ready, pop_valid, pop_ready;
   ctrl_type                      push_ctrl, pop_ctrl;
   logic signed [SAMPLE_BITS-1:0] push_sample, pop_sample;
   logic [CW-1:0]                 push_addr, pop_addr;
   logic [QW-1:0]                 pop_data;

   ccv_front #(
      .MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS),
      .TMPL_MAX(TMPL_MAX), .SAMPLE_BITS(SAMPLE_BITS)
   ) u_front (
      .clock(clock), .reset(reset), .req_chan(req_chan), .enable(!clear_busy),
      .rows(rows), .cols(cols), .tr(tr), .tc(tc),
      .push_valid(push_valid), .push_ready(push_ready), .push_ctrl(push_ctrl),
      .push_sample(push_sample), .push_addr(push_addr)
   );

   ccv_queue #(.WIDTH(QW)) u_queue (
      .clock(clock), .reset(reset),
      .push_valid(push_valid), .push_ready(push_ready),
      .push_data({push_ctrl, push_sample, push_addr}),
      .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_data)
   );

   assign {pop_ctrl, pop_sample, pop_addr} = pop_data;

   ccv_back #(
      .MAX_COLS(MAX_COLS), .TMPL_MAX(TMPL_MAX), .SAMPLE_BITS(SAMPLE_BITS)
   ) u_back (
      .clock(clock), .reset(reset),
      .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_ctrl(pop_ctrl),
      .pop_sample(pop_sample), .pop_addr(pop_addr), .tr(tr), .tc(tc),
      .clear_busy(clear_busy), .rsp_chan(rsp_chan)
   );

endmodule
